@@ rtl/overwriting_ring_with_offset_lookup_unit_assert.svh @@
// Assertion macros for the overwriting ring with offset lookup.
// Included by the module that checks its own logic; needs clk and arst_n in scope.
`ifndef OVERWRITING_RING_WITH_OFFSET_LOOKUP_UNIT_ASSERT_SVH
`define OVERWRITING_RING_WITH_OFFSET_LOOKUP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ORL_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("orl assertion failed");
`define ORL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orl assertion failed");
`else
`define ORL_ASSERT(lbl, expr)
`define ORL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/orl_pkg.sv @@
// Shared constants and types of the overwriting ring with offset lookup.
// No dependencies.
package orl_pkg;
	localparam int SLOTS       = 10;
	localparam int LENGTH_BITS = 16;
	localparam int TAG_BITS    = 32;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int POS_W  = 20;
	localparam int ACC_W  = LENGTH_BITS + SLOT_W + 1;
	localparam int CMP_W  = (ACC_W > POS_W) ? ACC_W : POS_W;

	localparam int LEN_IN_W   = 16;
	localparam int TAG_IO_W   = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int BYTE_W     = 16;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] acc;
		logic [CNT_W-1:0] remain;
	} probe_t;

	typedef struct packed {
		logic                done;
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic [TAG_BITS-1:0] tag;
		logic [BYTE_W-1:0]   byte_off;
	} report_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] hit_slot;
		logic [TAG_IO_W-1:0]   hit_tag;
		logic [BYTE_W-1:0]     byte_in_entry;
		logic                  evicted;
		logic [TAG_IO_W-1:0]   evicted_tag;
	} res_t;
endpackage

@@ rtl/orl_if.sv @@
// Valid/ready channels of the overwriting ring: request words in, result words out.
// Depends on orl_pkg.
interface orl_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [orl_pkg::LEN_IN_W-1:0]       entry_length;
	logic [orl_pkg::TAG_IO_W-1:0]       entry_tag;
	logic [orl_pkg::POS_W-1:0]          char_position;

	modport source (output valid, req_type, entry_length, entry_tag, char_position,
		input ready);
	modport sink (input valid, req_type, entry_length, entry_tag, char_position,
		output ready);
endinterface

interface orl_res_if;
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic [orl_pkg::SLOT_OUT_W-1:0]     hit_slot;
	logic [orl_pkg::TAG_IO_W-1:0]       hit_tag;
	logic [orl_pkg::BYTE_W-1:0]         byte_in_entry;
	logic                               evicted;
	logic [orl_pkg::TAG_IO_W-1:0]       evicted_tag;

	modport source (output valid, hit, hit_slot, hit_tag, byte_in_entry, evicted,
		evicted_tag, input ready);
	modport sink (input valid, hit, hit_slot, hit_tag, byte_in_entry, evicted,
		evicted_tag, output ready);
endinterface

@@ rtl/orl_cell.sv @@
// One ring slot: stored length and tag, plus the probe stage of the lookup walk.
// Depends on orl_pkg.
module orl_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [orl_pkg::SLOT_W-1:0]         slot_id,
	input  logic                               wr_en,
	input  logic [orl_pkg::LENGTH_BITS-1:0]    wr_length,
	input  logic [orl_pkg::TAG_BITS-1:0]       wr_tag,
	output logic [orl_pkg::TAG_BITS-1:0]       tag,
	input  orl_pkg::probe_t                    probe_in,
	output orl_pkg::probe_t                    probe_out,
	output orl_pkg::report_t                   report
);
	logic [orl_pkg::LENGTH_BITS-1:0] length_q;
	logic [orl_pkg::TAG_BITS-1:0]    tag_q;
	orl_pkg::probe_t                 probe_q;
	logic [orl_pkg::CMP_W-1:0]       sum;
	logic                            last;
	logic                            match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			length_q <= wr_length;
			tag_q    <= wr_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_in;
		end
	end

	assign tag   = tag_q;
	assign sum   = probe_q.acc + orl_pkg::CMP_W'(length_q);
	assign last  = (probe_q.remain == '0);
	assign match = probe_q.valid && !last && (probe_q.pos < sum);

	always_comb begin
		report          = '0;
		report.done     = probe_q.valid && (last || match);
		report.hit      = match;
		if (match) begin
			report.slot     = slot_id;
			report.tag      = tag_q;
			report.byte_off = orl_pkg::BYTE_W'(probe_q.pos - probe_q.acc);
		end
		probe_out        = probe_q;
		probe_out.valid  = probe_q.valid && !last && !match;
		probe_out.acc    = sum;
		probe_out.remain = probe_q.remain - orl_pkg::CNT_W'(1);
	end
endmodule

@@ rtl/overwriting_ring_with_offset_lookup_unit.sv @@
// Top level of the overwriting ring with offset lookup: ring pointers, walk control, result register.
// Depends on orl_pkg, orl_if.sv, orl_cell and the assert header.
//
//  channel | dir | handshake   | word
//  req     | in  | valid/ready | req_type, entry_length, entry_tag, char_position
//  res     | out | valid/ready | hit, hit_slot, hit_tag, byte_in_entry, evicted, evicted_tag
//
// Add: result registered at the accepting edge, or held in the spare register while res is stalled.
// Lookup: probe moves one cell per cycle from the oldest slot; the result is registered when the
// probe reaches the hit entry, or the slot after the last stored entry on a miss.
// One request in flight at a time; req is ready again once the result is registered.
// Reset clears pointers, full flag, probes, state and output; slot contents are unknown until written.
// A stalled result is held in a spare register; req is taken again once it reaches the output.
`include "overwriting_ring_with_offset_lookup_unit_assert.svh"

module overwriting_ring_with_offset_lookup_unit (
	input  logic     clk,
	input  logic     arst_n,
	orl_req_if.sink  req,
	orl_res_if.source res
);
	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_HOLD} state_t;

	state_t                         state_q;
	logic [orl_pkg::SLOT_W-1:0]     wr_idx_q;
	logic [orl_pkg::SLOT_W-1:0]     rd_idx_q;
	logic                           full_q;
	logic                           out_valid_q;
	orl_pkg::res_t                  out_q;
	orl_pkg::res_t                  res_q;

	orl_pkg::probe_t                probe_in  [orl_pkg::SLOTS];
	orl_pkg::probe_t                probe_out [orl_pkg::SLOTS];
	orl_pkg::report_t               report    [orl_pkg::SLOTS];
	logic [orl_pkg::TAG_BITS-1:0]   tags      [orl_pkg::SLOTS];
	logic [orl_pkg::SLOTS-1:0]      done_vec;
	logic [orl_pkg::SLOTS-1:0]      pvalid_vec;

	logic                           accept;
	logic                           is_add;
	logic                           is_look;
	logic                           out_free;
	logic                           done_any;
	logic                           new_valid;
	orl_pkg::report_t               merged;
	orl_pkg::res_t                  new_res;
	orl_pkg::probe_t                new_probe;
	logic [orl_pkg::CNT_W-1:0]      count;
	logic [orl_pkg::SLOT_W-1:0]     wr_next;
	logic [orl_pkg::SLOT_W-1:0]     rd_next;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_add    = accept && (req.req_type == orl_pkg::REQ_ADD);
	assign is_look   = accept && (req.req_type == orl_pkg::REQ_LOOKUP);
	assign out_free  = !out_valid_q || res.ready;

	assign wr_next = (wr_idx_q == orl_pkg::SLOT_W'(orl_pkg::SLOTS - 1)) ? '0
		: wr_idx_q + orl_pkg::SLOT_W'(1);
	assign rd_next = (rd_idx_q == orl_pkg::SLOT_W'(orl_pkg::SLOTS - 1)) ? '0
		: rd_idx_q + orl_pkg::SLOT_W'(1);

	always_comb begin
		if (full_q)
			count = orl_pkg::CNT_W'(orl_pkg::SLOTS);
		else if (wr_idx_q >= rd_idx_q)
			count = orl_pkg::CNT_W'(wr_idx_q - rd_idx_q);
		else
			count = orl_pkg::CNT_W'(wr_idx_q) + orl_pkg::CNT_W'(orl_pkg::SLOTS)
				- orl_pkg::CNT_W'(rd_idx_q);
		new_probe        = '0;
		new_probe.valid  = 1'b1;
		new_probe.pos    = orl_pkg::CMP_W'(req.char_position);
		new_probe.remain = count;
	end

	for (genvar k = 0; k < orl_pkg::SLOTS; k++) begin : g_cell
		localparam int PREV = (k + orl_pkg::SLOTS - 1) % orl_pkg::SLOTS;

		assign probe_in[k] = (is_look && rd_idx_q == orl_pkg::SLOT_W'(k)) ? new_probe
			: probe_out[PREV];
		assign done_vec[k]   = report[k].done;
		assign pvalid_vec[k] = probe_in[k].valid;

		orl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot_id   (orl_pkg::SLOT_W'(k)),
			.wr_en     (is_add && wr_idx_q == orl_pkg::SLOT_W'(k)),
			.wr_length (orl_pkg::LENGTH_BITS'(req.entry_length)),
			.wr_tag    (orl_pkg::TAG_BITS'(req.entry_tag)),
			.tag       (tags[k]),
			.probe_in  (probe_in[k]),
			.probe_out (probe_out[k]),
			.report    (report[k])
		);
	end

	always_comb begin
		merged = '0;
		for (int k = 0; k < orl_pkg::SLOTS; k++)
			merged = merged | report[k];
	end

	assign done_any  = |done_vec;
	assign new_valid = is_add || (state_q == ST_WALK && done_any);

	always_comb begin
		new_res = '0;
		if (is_add) begin
			new_res.evicted = full_q;
			if (full_q)
				new_res.evicted_tag = orl_pkg::TAG_IO_W'(tags[wr_idx_q]);
		end else begin
			new_res.hit           = merged.hit;
			new_res.hit_slot      = orl_pkg::SLOT_OUT_W'(merged.slot);
			new_res.hit_tag       = orl_pkg::TAG_IO_W'(merged.tag);
			new_res.byte_in_entry = merged.byte_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			full_q   <= 1'b0;
		end else if (is_add) begin
			wr_idx_q <= wr_next;
			if (full_q)
				rd_idx_q <= rd_next;
			else if (wr_next == rd_idx_q)
				full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
		end else begin
			if (out_free) begin
				if (state_q == ST_HOLD) begin
					out_q       <= res_q;
					out_valid_q <= 1'b1;
				end else if (new_valid) begin
					out_q       <= new_res;
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (is_look) begin
						state_q <= ST_WALK;
					end else if (is_add && !out_free) begin
						res_q   <= new_res;
						state_q <= ST_HOLD;
					end
				end
				ST_WALK: begin
					if (done_any) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							res_q   <= new_res;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.hit           = out_q.hit;
	assign res.hit_slot      = out_q.hit_slot;
	assign res.hit_tag       = out_q.hit_tag;
	assign res.byte_in_entry = out_q.byte_in_entry;
	assign res.evicted       = out_q.evicted;
	assign res.evicted_tag   = out_q.evicted_tag;

	`ORL_ASSERT(a_one_done, $onehot0(done_vec))
	`ORL_ASSERT(a_done_in_walk, !done_any || state_q == ST_WALK)
	`ORL_ASSERT(a_full_ptrs, !full_q || wr_idx_q == rd_idx_q)
	`ORL_ASSERT_NEXT(a_probe_idle, state_q != ST_WALK && !is_look, is_look || pvalid_vec == '0)
endmodule
